// File: hw/rtl/tprs_pkg.sv
package tprs_pkg;

    // Sizing of the task table and the priority rings.
    localparam int NUM_TASKS      = 64;
    localparam int NUM_PRIORITIES = 16;
    localparam int RING_DEPTH     = 64;

    // Port field widths, fixed by the command format.
    localparam int CMD_W    = 2;
    localparam int TID_W    = 6;
    localparam int PRI_IN_W = 5;
    localparam int ENTRY_W  = 32;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 7;

    // Internal widths derived from the sizing.
    localparam int IDX_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PRIO_W  = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SLOT_AW = (NUM_PRIORITIES * RING_DEPTH > 1) ?
                             $clog2(NUM_PRIORITIES * RING_DEPTH) : 1;
    localparam int SLOTS   = NUM_PRIORITIES * RING_DEPTH;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RING_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RING_EMPTY = 3'd4;

    // Task descriptor states.
    localparam logic [1:0] TS_FREE   = 2'd0;
    localparam logic [1:0] TS_READY  = 2'd1;
    localparam logic [1:0] TS_ZOMBIE = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_COMMIT = 8'b0000_0100,
        S_PRD    = 8'b0000_1000,
        S_YUPD   = 8'b0001_0000,
        S_XUPD   = 8'b0010_0000,
        S_DONE   = 8'b0100_0000
    } seq_state_t;

    // Advance a ring pointer with wrap.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
        ring_next = (i == PTR_W'(RING_DEPTH - 1)) ? '0 : i + PTR_W'(1);
    endfunction

endpackage

// File: hw/rtl/task_table_priority_ring_scheduler.sv
// Task table with one ring of task ids per priority, driven by a small sequencer.
// A create scans the descriptors from just past the last issued id, probing one entry per cycle
// through the registered state memory, commits the new task and then yields the caller; yield
// and exit read the caller's priority and then update its ring; a bad priority or the unused
// code goes straight to the result. One command at a time: the next input transfer comes in
// the cycle the result appears at the earliest. Reset clears the sequencer, ring pointers,
// live count and state valid bits, and sets the last issued id to the top of the table.
module task_table_priority_ring_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tprs_pkg::CMD_W-1:0]      cmd,
    input  logic [tprs_pkg::TID_W-1:0]      caller_tid,
    input  logic [tprs_pkg::PRI_IN_W-1:0]   new_priority,
    input  logic [tprs_pkg::ENTRY_W-1:0]    entry_address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tprs_pkg::STATUS_W-1:0]   status,
    output logic [tprs_pkg::TID_W-1:0]      tid_out,
    output logic [tprs_pkg::LIVE_W-1:0]     live_tasks
);

    localparam int IDX_W   = tprs_pkg::IDX_W;
    localparam int PRIO_W  = tprs_pkg::PRIO_W;
    localparam int PTR_W   = tprs_pkg::PTR_W;
    localparam int CNT_W   = tprs_pkg::CNT_W;
    localparam int SLOT_AW = tprs_pkg::SLOT_AW;

    // Memories. The state memory has a valid bit per entry so that an entry that
    // was never written reads as free.
    logic [1:0]                     st_mem    [tprs_pkg::NUM_TASKS];
    logic [PRIO_W-1:0]              prio_mem  [tprs_pkg::NUM_TASKS];
    logic [tprs_pkg::ENTRY_W-1:0]   entry_mem [tprs_pkg::NUM_TASKS];
    logic [tprs_pkg::TID_W-1:0]     slot_mem  [tprs_pkg::SLOTS];

    logic [tprs_pkg::NUM_TASKS-1:0] st_valid_reg;
    logic [1:0]                     st_rdata_reg;
    logic                           st_vbit_reg;
    logic [PRIO_W-1:0]              prio_rdata_reg;

    // Per-priority ring pointers, small enough to live in flops.
    logic [PTR_W-1:0] ring_head_reg  [tprs_pkg::NUM_PRIORITIES];
    logic [PTR_W-1:0] ring_tail_reg  [tprs_pkg::NUM_PRIORITIES];
    logic [CNT_W-1:0] ring_count_reg [tprs_pkg::NUM_PRIORITIES];

    // Sequencer and control registers.
    tprs_pkg::seq_state_t           state_reg, state_next;
    logic [IDX_W-1:0]               scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]               probe_addr_reg;
    logic                           probe_vld_reg, probe_vld_next;
    logic [IDX_W-1:0]               last_issued_reg, last_issued_next;
    logic [tprs_pkg::LIVE_W-1:0]    alive_reg, alive_next;
    logic                           out_valid_reg, out_valid_next;

    // Command payload and result holding registers.
    logic [tprs_pkg::CMD_W-1:0]     cmd_reg;
    logic [tprs_pkg::TID_W-1:0]     caller_reg;
    logic [tprs_pkg::PRI_IN_W-1:0]  prio_reg;
    logic [tprs_pkg::ENTRY_W-1:0]   entry_reg;
    logic [IDX_W-1:0]               tid_reg, tid_next;
    logic [tprs_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [tprs_pkg::TID_W-1:0]     res_tid_reg, res_tid_next;
    logic [tprs_pkg::STATUS_W-1:0]  out_status_reg;
    logic [tprs_pkg::TID_W-1:0]     out_tid_reg;
    logic [tprs_pkg::LIVE_W-1:0]    out_live_reg;

    // Write ports and ring update, driven by the sequencer.
    logic                           st_we;
    logic [IDX_W-1:0]               st_waddr;
    logic [1:0]                     st_wdata;
    logic                           sl_we;
    logic [SLOT_AW-1:0]             sl_waddr;
    logic [tprs_pkg::TID_W-1:0]     sl_wdata;
    logic [PTR_W-1:0]               sl_slot;
    logic                           commit_we;
    logic                           ring_we;
    logic [PRIO_W-1:0]              ring_p;
    logic [PTR_W-1:0]               head_new, tail_new;
    logic [CNT_W-1:0]               count_new;

    logic                           in_xfer;
    logic                           out_load;
    logic                           caller_in_ok;
    logic                           caller_reg_ok;
    logic                           probe_free;
    logic [PRIO_W-1:0]              prio_eff;
    logic [PTR_W-1:0]               head_cur, tail_cur;
    logic [CNT_W-1:0]               count_cur;
    logic [IDX_W-1:0]               scan_start;
    logic [IDX_W-1:0]               caller_idx;

    assign in_ready   = (state_reg == tprs_pkg::S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign out_load   = (state_reg == tprs_pkg::S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign tid_out    = out_tid_reg;
    assign live_tasks = out_live_reg;

    assign caller_in_ok  = (32'(caller_tid) < tprs_pkg::NUM_TASKS);
    assign caller_reg_ok = (32'(caller_reg) < tprs_pkg::NUM_TASKS);
    assign caller_idx    = IDX_W'(caller_reg);

    // The scan starts just after the last issued id and wraps to zero only there.
    assign scan_start = (last_issued_reg == IDX_W'(tprs_pkg::NUM_TASKS - 1)) ?
                        '0 : last_issued_reg + IDX_W'(1);

    assign probe_free = !st_vbit_reg || (st_rdata_reg == tprs_pkg::TS_FREE);

    // A stored priority outside the ring range falls back to ring zero.
    assign prio_eff = (32'(prio_rdata_reg) < tprs_pkg::NUM_PRIORITIES) ? prio_rdata_reg : '0;

    // One ring is touched per cycle: the new task's ring during scan and commit,
    // the caller's ring during yield and exit updates.
    assign ring_p    = ((state_reg == tprs_pkg::S_YUPD) || (state_reg == tprs_pkg::S_XUPD)) ?
                       prio_eff : PRIO_W'(prio_reg);
    assign head_cur  = ring_head_reg[ring_p];
    assign tail_cur  = ring_tail_reg[ring_p];
    assign count_cur = ring_count_reg[ring_p];

    assign sl_waddr  = SLOT_AW'(32'(ring_p) * tprs_pkg::RING_DEPTH + 32'(sl_slot));

    always_comb
    begin
        state_next       = state_reg;
        scan_addr_next   = scan_addr_reg;
        probe_vld_next   = probe_vld_reg;
        last_issued_next = last_issued_reg;
        alive_next       = alive_reg;
        tid_next         = tid_reg;
        res_status_next  = res_status_reg;
        res_tid_next     = res_tid_reg;
        st_we            = 1'b0;
        st_waddr         = caller_idx;
        st_wdata         = tprs_pkg::TS_READY;
        sl_we            = 1'b0;
        sl_slot          = tail_cur;
        sl_wdata         = caller_reg;
        commit_we        = 1'b0;
        ring_we          = 1'b0;
        head_new         = head_cur;
        tail_new         = tail_cur;
        count_new        = count_cur;

        case (state_reg)
            tprs_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    res_status_next = tprs_pkg::ST_OK;
                    res_tid_next    = '0;
                    scan_addr_next  = scan_start;
                    probe_vld_next  = 1'b0;
                    case (cmd)
                        tprs_pkg::CMD_CREATE:
                        begin
                            if (32'(new_priority) >= tprs_pkg::NUM_PRIORITIES)
                            begin
                                res_status_next = tprs_pkg::ST_BAD_PRIO;
                                state_next      = tprs_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = tprs_pkg::S_SCAN;
                            end
                        end
                        tprs_pkg::CMD_YIELD:
                        begin
                            res_tid_next = caller_tid;
                            state_next   = caller_in_ok ? tprs_pkg::S_PRD : tprs_pkg::S_DONE;
                        end
                        tprs_pkg::CMD_EXIT:
                        begin
                            state_next = caller_in_ok ? tprs_pkg::S_PRD : tprs_pkg::S_DONE;
                        end
                        default:
                        begin
                            state_next = tprs_pkg::S_DONE;
                        end
                    endcase
                end
            end

            tprs_pkg::S_SCAN:
            begin
                // One probe is issued per cycle; its answer is registered and returns in the following cycle.
                probe_vld_next = 1'b1;
                scan_addr_next = scan_addr_reg + IDX_W'(1);
                if (probe_vld_reg && probe_free)
                begin
                    tid_next = probe_addr_reg;
                    if (32'(count_cur) >= tprs_pkg::RING_DEPTH)
                    begin
                        res_status_next = tprs_pkg::ST_RING_FULL;
                        state_next      = tprs_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = tprs_pkg::S_COMMIT;
                    end
                end
                else if (probe_vld_reg &&
                         (probe_addr_reg == IDX_W'(tprs_pkg::NUM_TASKS - 1)))
                begin
                    res_status_next = tprs_pkg::ST_NO_FREE;
                    state_next      = tprs_pkg::S_DONE;
                end
            end

            tprs_pkg::S_COMMIT:
            begin
                st_we            = 1'b1;
                st_waddr         = tid_reg;
                st_wdata         = tprs_pkg::TS_READY;
                commit_we        = 1'b1;
                last_issued_next = tid_reg;
                alive_next       = alive_reg + tprs_pkg::LIVE_W'(1);
                ring_we          = 1'b1;
                count_new        = count_cur + CNT_W'(1);
                if (count_cur == '0)
                begin
                    head_new = '0;
                    tail_new = '0;
                end
                else
                begin
                    tail_new = tprs_pkg::ring_next(tail_cur);
                end
                sl_we        = 1'b1;
                sl_slot      = tail_new;
                sl_wdata     = tprs_pkg::TID_W'(tid_reg);
                res_tid_next = tprs_pkg::TID_W'(tid_reg);
                // The caller's priority is read only after this write has landed.
                state_next   = caller_reg_ok ? tprs_pkg::S_PRD : tprs_pkg::S_DONE;
            end

            tprs_pkg::S_PRD:
            begin
                state_next = (cmd_reg == tprs_pkg::CMD_EXIT) ? tprs_pkg::S_XUPD :
                                                               tprs_pkg::S_YUPD;
            end

            tprs_pkg::S_YUPD:
            begin
                st_we    = 1'b1;
                st_wdata = tprs_pkg::TS_READY;
                if (count_cur > CNT_W'(1))
                begin
                    ring_we  = 1'b1;
                    head_new = tprs_pkg::ring_next(head_cur);
                    tail_new = tprs_pkg::ring_next(tail_cur);
                    sl_we    = 1'b1;
                    sl_slot  = tail_new;
                    sl_wdata = caller_reg;
                end
                state_next = tprs_pkg::S_DONE;
            end

            tprs_pkg::S_XUPD:
            begin
                if (count_cur == '0)
                begin
                    res_status_next = tprs_pkg::ST_RING_EMPTY;
                end
                else
                begin
                    st_we     = 1'b1;
                    st_wdata  = tprs_pkg::TS_ZOMBIE;
                    ring_we   = 1'b1;
                    head_new  = tprs_pkg::ring_next(head_cur);
                    count_new = count_cur - CNT_W'(1);
                    if (alive_reg != '0)
                    begin
                        alive_next = alive_reg - tprs_pkg::LIVE_W'(1);
                    end
                end
                state_next = tprs_pkg::S_DONE;
            end

            tprs_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = tprs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tprs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tprs_pkg::S_IDLE;
            scan_addr_reg   <= '0;
            probe_vld_reg   <= 1'b0;
            last_issued_reg <= IDX_W'(tprs_pkg::NUM_TASKS - 1);
            alive_reg       <= '0;
            out_valid_reg   <= 1'b0;
            st_valid_reg    <= '0;
            for (int i = 0; i < tprs_pkg::NUM_PRIORITIES; i++)
            begin
                ring_head_reg[i]  <= '0;
                ring_tail_reg[i]  <= '0;
                ring_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            scan_addr_reg   <= scan_addr_next;
            probe_vld_reg   <= probe_vld_next;
            last_issued_reg <= last_issued_next;
            alive_reg       <= alive_next;
            out_valid_reg   <= out_valid_next;
            if (st_we)
            begin
                st_valid_reg[st_waddr] <= 1'b1;
            end
            if (ring_we)
            begin
                ring_head_reg[ring_p]  <= head_new;
                ring_tail_reg[ring_p]  <= tail_new;
                ring_count_reg[ring_p] <= count_new;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg    <= cmd;
            caller_reg <= caller_tid;
            prio_reg   <= new_priority;
            entry_reg  <= entry_address;
        end
        tid_reg        <= tid_next;
        res_status_reg <= res_status_next;
        res_tid_reg    <= res_tid_next;
        probe_addr_reg <= scan_addr_reg;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_tid_reg    <= res_tid_reg;
            out_live_reg   <= alive_reg;
        end
    end

    // Task state memory: one write port, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= st_mem[scan_addr_reg];
        st_vbit_reg  <= st_valid_reg[scan_addr_reg];
    end

    // Priority memory, always read at the caller's id.
    always_ff @(posedge clk)
    begin
        if (commit_we)
        begin
            prio_mem[tid_reg] <= PRIO_W'(prio_reg);
        end
        prio_rdata_reg <= prio_mem[caller_idx];
    end

    // Entry address memory.
    always_ff @(posedge clk)
    begin
        if (commit_we)
        begin
            entry_mem[tid_reg] <= entry_reg;
        end
    end

    // Ring slot memory, addressed by priority and slot.
    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            slot_mem[sl_waddr] <= sl_wdata;
        end
    end

`ifndef ASSERT_OFF
    a_alive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(alive_reg) <= tprs_pkg::NUM_TASKS)
        else $error("live task count exceeds the table size");

    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> (32'(count_new) <= tprs_pkg::RING_DEPTH))
        else $error("ring count update exceeds the ring depth");

    a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tprs_pkg::S_COMMIT) |=> (last_issued_reg == $past(tid_reg)))
        else $error("last issued id not updated by a create");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken again while a command is in progress");

    a_scan_found_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tprs_pkg::S_COMMIT) |-> ($past(probe_free) && $past(probe_vld_reg)))
        else $error("create committed without a free descriptor");
`endif

endmodule

// File: verif/tb_task_table_priority_ring_scheduler.sv
`timescale 1ns / 100ps

module tb_task_table_priority_ring_scheduler;

    // The command port carries one code that the block does not use; it must be ignored.
    localparam logic [tprs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Random calls, not counting calls with the unused code. With the
    // directed rows and the unused codes the run sends about 450 calls.
    localparam int RANDOM_CALLS = 410;
    // Far above the slowest correct run: every call waiting out both sides' longest gaps
    // plus a full descriptor scan, and the one long hold on the result side.
    localparam int CYCLE_LIMIT  = 400000;

    // One result of a system call, as the block reports it.
    typedef struct packed {
        logic [tprs_pkg::STATUS_W-1:0] st;
        logic [tprs_pkg::TID_W-1:0]    id;
        logic [tprs_pkg::LIVE_W-1:0]   alive;
    } call_result_t;

    // One row of the directed table. Where hand_checked is set, the expected result is
    // typed into the row; otherwise it comes from the scheduler model below.
    typedef struct {
        logic [tprs_pkg::CMD_W-1:0]    op;
        logic [tprs_pkg::TID_W-1:0]    caller;
        logic [tprs_pkg::PRI_IN_W-1:0] prio;
        logic [tprs_pkg::ENTRY_W-1:0]  entry;
        bit                            hand_checked;
        call_result_t                  want;
    } call_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [tprs_pkg::CMD_W-1:0]      cmd;
    logic [tprs_pkg::TID_W-1:0]      caller_tid;
    logic [tprs_pkg::PRI_IN_W-1:0]   new_priority;
    logic [tprs_pkg::ENTRY_W-1:0]    entry_address;
    logic                            out_valid;
    logic                            out_ready;
    logic [tprs_pkg::STATUS_W-1:0]   status;
    logic [tprs_pkg::TID_W-1:0]      tid_out;
    logic [tprs_pkg::LIVE_W-1:0]     live_tasks;

    task_table_priority_ring_scheduler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .caller_tid    (caller_tid),
        .new_priority  (new_priority),
        .entry_address (entry_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .tid_out       (tid_out),
        .live_tasks    (live_tasks)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------
    // Scheduler model.
    // Only what can reach an output is kept. The ring slots, the ring pointers and the
    // entry addresses never show up in a result, so each ring is tracked by its fill
    // count alone. Descriptor state matters only through the free test of the scan.
    // ------------------------------------------------------------------------------
    logic [1:0]                  desc_state [tprs_pkg::NUM_TASKS];
    logic [tprs_pkg::PRIO_W-1:0] desc_prio  [tprs_pkg::NUM_TASKS];
    int                          ring_fill  [tprs_pkg::NUM_PRIORITIES];
    int                          last_issued_id;
    int                          alive_tasks;

    // Ids that have been issued at least once. Only these may call yield or exit, or
    // be the caller of a create, because the block would otherwise look up the priority
    // of a descriptor that was never written.
    logic [tprs_pkg::TID_W-1:0]  issued_ids [$];

    // Results still owed by the block, oldest first.
    call_result_t                owed_results [$];

    call_row_t                   directed_calls [$];

    int                          mismatches = 0;
    int                          cycle_count = 0;
    int                          calls_sent;
    int                          calls_by_op [4];
    int                          results_by_status [8] = '{default: 0};

    function automatic call_result_t schedule_call(
        input logic [tprs_pkg::CMD_W-1:0]    op,
        input logic [tprs_pkg::TID_W-1:0]    caller,
        input logic [tprs_pkg::PRI_IN_W-1:0] prio);
        call_result_t                r;
        int                          t;
        logic [tprs_pkg::PRIO_W-1:0] p;
        bit                          found;
        r.st = tprs_pkg::ST_OK;
        r.id = '0;
        if (op == tprs_pkg::CMD_CREATE)
        begin
            if (prio >= tprs_pkg::NUM_PRIORITIES)
            begin
                r.st = tprs_pkg::ST_BAD_PRIO;
            end
            else
            begin
                p = tprs_pkg::PRIO_W'(prio);
                // The scan starts just past the last issued id and wraps to zero only
                // when that start falls off the end; it never wraps a second time.
                t = last_issued_id + 1;
                if (t >= tprs_pkg::NUM_TASKS)
                    t = 0;
                found = 1'b0;
                while (t < tprs_pkg::NUM_TASKS && !found)
                begin
                    if (desc_state[tprs_pkg::IDX_W'(t)] == tprs_pkg::TS_FREE)
                        found = 1'b1;
                    else
                        t++;
                end
                if (!found)
                begin
                    r.st = tprs_pkg::ST_NO_FREE;
                end
                else if (ring_fill[p] >= tprs_pkg::RING_DEPTH)
                begin
                    r.st = tprs_pkg::ST_RING_FULL;
                end
                else
                begin
                    last_issued_id = t;
                    alive_tasks++;
                    desc_state[tprs_pkg::IDX_W'(t)] = tprs_pkg::TS_READY;
                    desc_prio[tprs_pkg::IDX_W'(t)]  = p;
                    ring_fill[p]++;
                    issued_ids.push_back(t[tprs_pkg::TID_W-1:0]);
                    // The caller is then yielded: its ring rotates but keeps its fill.
                    desc_state[caller] = tprs_pkg::TS_READY;
                    r.id = t[tprs_pkg::TID_W-1:0];
                end
            end
        end
        else if (op == tprs_pkg::CMD_YIELD)
        begin
            // Every 6-bit caller is inside the task table, so the out-of-range
            // caller case cannot occur at this size.
            desc_state[caller] = tprs_pkg::TS_READY;
            r.id = caller;
        end
        else if (op == tprs_pkg::CMD_EXIT)
        begin
            p = desc_prio[caller];
            if (ring_fill[p] == 0)
            begin
                r.st = tprs_pkg::ST_RING_EMPTY;
            end
            else
            begin
                desc_state[caller] = tprs_pkg::TS_ZOMBIE;
                ring_fill[p]--;
                if (alive_tasks > 0)
                    alive_tasks--;
            end
        end
        r.alive = alive_tasks[tprs_pkg::LIVE_W-1:0];
        return r;
    endfunction

    function automatic call_row_t call_row(input logic [tprs_pkg::CMD_W-1:0]    op,
                                           input logic [tprs_pkg::TID_W-1:0]    caller,
                                           input logic [tprs_pkg::PRI_IN_W-1:0] prio,
                                           input logic [tprs_pkg::ENTRY_W-1:0]  entry,
                                           input bit                            hand_checked,
                                           input logic [tprs_pkg::STATUS_W-1:0] st,
                                           input logic [tprs_pkg::TID_W-1:0]    id,
                                           input logic [tprs_pkg::LIVE_W-1:0]   alive);
        call_row_t row;
        row.op           = op;
        row.caller       = caller;
        row.prio         = prio;
        row.entry        = entry;
        row.hand_checked = hand_checked;
        row.want         = '{st: st, id: id, alive: alive};
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one call after a random gap, holds it until the block takes it, and then
    // books the result the block owes for it. Some stretches run with no gaps at all.
    task automatic offer_call(input logic [tprs_pkg::CMD_W-1:0]    op,
                              input logic [tprs_pkg::TID_W-1:0]    caller,
                              input logic [tprs_pkg::PRI_IN_W-1:0] prio,
                              input logic [tprs_pkg::ENTRY_W-1:0]  entry,
                              input bit                            hand_checked,
                              input call_result_t                  want);
        int           gap;
        call_result_t predicted;
        gap = ((calls_sent / 40) % 5 == 4) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd           <= op;
        caller_tid    <= caller;
        new_priority  <= prio;
        entry_address <= entry;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = schedule_call(op, caller, prio);
        owed_results.push_back(hand_checked ? want : predicted);
        calls_sent++;
        calls_by_op[op]++;
    endtask

    function automatic logic [tprs_pkg::TID_W-1:0] any_issued_id();
        return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
    endfunction

    // Priorities lean toward a few low values so that rings hold several tasks at once.
    function automatic logic [tprs_pkg::PRI_IN_W-1:0] busy_priority();
        if ($urandom_range(0, 3) != 0)
            return tprs_pkg::PRI_IN_W'($urandom_range(0, 3));
        return tprs_pkg::PRI_IN_W'($urandom_range(0, tprs_pkg::NUM_PRIORITIES - 1));
    endfunction

    // ------------------------------------------------------------------------------
    // Result side: a random hold before each transfer, stretches with no hold, and one
    // long hold partway through so that the block backs up and stalls its input.
    // ------------------------------------------------------------------------------
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken == 200)
                gap = 300;
            else if ((taken / 40) % 5 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            taken++;
        end
    end

    // Each transfer on the result side is checked field by field against the oldest
    // result still owed.
    always @(posedge clk)
    begin
        call_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_by_status[status]++;
            if (owed_results.size() == 0)
            begin
                report_mismatch("result count (result with nothing owed)", 1, 0);
            end
            else
            begin
                want = owed_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", int'(status), int'(want.st));
                if (tid_out !== want.id)
                    report_mismatch("tid_out", int'(tid_out), int'(want.id));
                if (live_tasks !== want.alive)
                    report_mismatch("live_tasks", int'(live_tasks), int'(want.alive));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results owed",
                     cycle_count, owed_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int                            useful;
        int                            pick;
        logic [tprs_pkg::CMD_W-1:0]    op;
        logic [tprs_pkg::TID_W-1:0]    caller;
        logic [tprs_pkg::PRI_IN_W-1:0] prio;
        call_result_t                  none;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        out_ready     <= 1'b0;
        cmd           <= tprs_pkg::CMD_YIELD;
        caller_tid    <= '0;
        new_priority  <= '0;
        entry_address <= '0;
        calls_sent     = 0;
        calls_by_op    = '{default: 0};
        none           = '0;

        // Model reset: every descriptor free, every ring empty, the scan set to start
        // at id zero.
        for (int i = 0; i < tprs_pkg::NUM_TASKS; i++)
        begin
            desc_state[i] = tprs_pkg::TS_FREE;
            desc_prio[i]  = '0;
        end
        for (int i = 0; i < tprs_pkg::NUM_PRIORITIES; i++)
            ring_fill[i] = 0;
        last_issued_id = tprs_pkg::NUM_TASKS - 1;
        alive_tasks    = 0;

        // Directed calls. The first rows start from reset, so their results can be
        // worked out by hand: bad priorities at the edge and at the top of the field, the
        // unused code, the first two creates at both ends of the priority range, and an
        // exit that drains a ring followed by an exit on the now empty ring. The later
        // rows rotate a shared ring, revive a zombie through yield, and drain again.
        directed_calls.push_back(call_row(tprs_pkg::CMD_CREATE, 6'd0, 5'd16, 32'h0000_0000,
                                          1'b1, tprs_pkg::ST_BAD_PRIO, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_CREATE, 6'd63, 5'd31, 32'hFFFF_FFFF,
                                          1'b1, tprs_pkg::ST_BAD_PRIO, 6'd0, 7'd0));
        directed_calls.push_back(call_row(CMD_UNUSED, 6'd63, 5'd31, 32'hFFFF_FFFF,
                                          1'b1, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_CREATE, 6'd0, 5'd0, 32'h0000_0000,
                                          1'b1, tprs_pkg::ST_OK, 6'd0, 7'd1));
        directed_calls.push_back(call_row(tprs_pkg::CMD_CREATE, 6'd0, 5'd15, 32'hFFFF_FFFF,
                                          1'b1, tprs_pkg::ST_OK, 6'd1, 7'd2));
        directed_calls.push_back(call_row(tprs_pkg::CMD_YIELD, 6'd1, 5'd0, 32'h0000_0000,
                                          1'b1, tprs_pkg::ST_OK, 6'd1, 7'd2));
        directed_calls.push_back(call_row(tprs_pkg::CMD_EXIT, 6'd1, 5'd0, 32'h0000_0000,
                                          1'b1, tprs_pkg::ST_OK, 6'd0, 7'd1));
        directed_calls.push_back(call_row(tprs_pkg::CMD_EXIT, 6'd1, 5'd0, 32'h0000_0000,
                                          1'b1, tprs_pkg::ST_RING_EMPTY, 6'd0, 7'd1));
        directed_calls.push_back(call_row(tprs_pkg::CMD_YIELD, 6'd1, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_CREATE, 6'd1, 5'd0, 32'h1234_5678,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_CREATE, 6'd2, 5'd0, 32'hA5A5_A5A5,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_YIELD, 6'd0, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_YIELD, 6'd3, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_EXIT, 6'd2, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_CREATE, 6'd0, 5'd7, 32'h5A5A_5A5A,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_EXIT, 6'd0, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_EXIT, 6'd3, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_EXIT, 6'd0, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(CMD_UNUSED, 6'd0, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));
        directed_calls.push_back(call_row(tprs_pkg::CMD_YIELD, 6'd4, 5'd0, 32'h0,
                                          1'b0, tprs_pkg::ST_OK, 6'd0, 7'd0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_calls[i])
            offer_call(directed_calls[i].op, directed_calls[i].caller, directed_calls[i].prio,
                       directed_calls[i].entry, directed_calls[i].hand_checked,
                       directed_calls[i].want);

        // Random calls. Most are well formed: callers are ids that were issued, so
        // rings fill, rotate and drain. Creates keep coming after the table runs out of
        // free descriptors, which exercises the failed scan. Bad priorities and the
        // unused code carry fully random callers, since neither looks the caller up.
        useful = 0;
        while (useful < RANDOM_CALLS)
        begin
            pick   = $urandom_range(0, 99);
            caller = any_issued_id();
            prio   = busy_priority();
            if (pick < 5)
            begin
                op     = CMD_UNUSED;
                caller = tprs_pkg::TID_W'($urandom);
                prio   = tprs_pkg::PRI_IN_W'($urandom);
            end
            else if (pick < 12)
            begin
                op     = tprs_pkg::CMD_CREATE;
                caller = tprs_pkg::TID_W'($urandom);
                prio   = tprs_pkg::PRI_IN_W'($urandom_range(tprs_pkg::NUM_PRIORITIES, 31));
            end
            else if (pick < 40)
            begin
                op = tprs_pkg::CMD_CREATE;
            end
            else if (pick < 75)
            begin
                op = tprs_pkg::CMD_YIELD;
            end
            else
            begin
                op = tprs_pkg::CMD_EXIT;
            end
            offer_call(op, caller, prio, tprs_pkg::ENTRY_W'($urandom), 1'b0, none);
            if (op != CMD_UNUSED)
                useful++;
        end
        in_valid <= 1'b0;

        // Drain, then keep the clock running so that any stray result still shows.
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (tprs_pkg::NUM_TASKS + 10) @(posedge clk);

        $display("Ran %0d calls: %0d create, %0d yield, %0d exit, %0d unused; %0d ids issued.",
                 calls_sent, calls_by_op[tprs_pkg::CMD_CREATE],
                 calls_by_op[tprs_pkg::CMD_YIELD], calls_by_op[tprs_pkg::CMD_EXIT],
                 calls_by_op[CMD_UNUSED], issued_ids.size());
        $display("Results seen: ok %0d, bad priority %0d, no free %0d, ring empty %0d.",
                 results_by_status[tprs_pkg::ST_OK], results_by_status[tprs_pkg::ST_BAD_PRIO],
                 results_by_status[tprs_pkg::ST_NO_FREE],
                 results_by_status[tprs_pkg::ST_RING_EMPTY]);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
